// ===== hdl/wpu_pkg.sv =====
// -----------------------------------------------------------------------------
// WAV PCM stream unpacker package
// Shared types, register map and constants for the data-chunk unpacker.
// -----------------------------------------------------------------------------
package wpu_pkg;

  // Input item: one byte of the file stream and a parser restart flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  // Result item: one decoded sample with its channel index.
  typedef struct packed {
    logic signed [23:0] sample;
    logic [3:0]         channel;
    logic               last_in_data;
  } out_item_t;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Configuration registers as seen by the parser.
  typedef struct packed {
    logic [1:0] sample_bytes;
    logic [4:0] channel_count;
  } cfg_t;

  // Register map: register i sits at byte address 4*i.
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_BYTES  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic [1:0] SAMPLE_BYTES_RST  = 2'd2;
  localparam logic [4:0] CHANNEL_COUNT_RST = 5'd1;

  // Marker "dat" held in the window, followed by the byte 'a'.
  localparam logic [23:0] MARK_DAT = 24'h646174;
  localparam logic [7:0]  MARK_A   = 8'h61;

  // Offset that turns an unsigned 8-bit sample into two's complement.
  localparam logic [7:0] SAMPLE_BIAS = 8'h80;

  localparam int unsigned DEF_MAX_CHANNELS = 16;

endpackage

// ===== hdl/wav_pcm_stream_unpacker.sv =====
// -----------------------------------------------------------------------------
// WAV PCM stream unpacker
// Finds the "data" chunk in a WAV byte stream and emits its PCM samples.
// -----------------------------------------------------------------------------
// The block takes one byte of the file stream per cycle unless stalled: a
// byte is held in an input register, decoded by the parser, and any finished
// sample is placed in an output register. The input side stalls only while a
// finished sample waits in the output register and the next held byte would
// produce another one. Bytes before the "data" marker and the four length
// bytes produce no result; after the last whole frame, bytes are absorbed
// with no result until a request with restart set. The user must write
// configuration through the APB port only while the stream is idle; the
// block itself does not enforce it.
// -----------------------------------------------------------------------------
module wav_pcm_stream_unpacker #(
  parameter int unsigned MAX_CHANNELS = wpu_pkg::DEF_MAX_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpu_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wpu_pkg::in_item_t            item,
  input  logic                         item_valid,
  output logic                         item_ready,
  output wpu_pkg::out_item_t           result,
  output logic                         result_valid,
  input  logic                         result_ready
);

  wpu_pkg::cfg_t      cfg;
  wpu_pkg::in_item_t  item_q;
  logic               item_q_valid;
  logic               advance;
  logic               emit;
  wpu_pkg::out_item_t res;

  assign pready = 1'b1;

  wpu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  wpu_core #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .emit    (emit),
    .res     (res)
  );

  // The held byte moves on unless its sample would overwrite a waiting one.
  assign advance    = item_q_valid && (!emit || !result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= res;
    end
  end

endmodule

// ===== hdl/wpu_regs.sv =====
// -----------------------------------------------------------------------------
// WPU configuration registers
// APB-style register file holding the sample width and channel count.
// -----------------------------------------------------------------------------
module wpu_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpu_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output wpu_pkg::cfg_t                cfg
);

  logic [wpu_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[wpu_pkg::ADDR_W-1:2];
  // The port is always ready, so the access phase completes the write.
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_bytes  <= wpu_pkg::SAMPLE_BYTES_RST;
      cfg.channel_count <= wpu_pkg::CHANNEL_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        wpu_pkg::REG_SAMPLE_BYTES:  cfg.sample_bytes  <= pwdata[1:0];
        wpu_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      wpu_pkg::REG_SAMPLE_BYTES:  prdata = {30'd0, cfg.sample_bytes};
      wpu_pkg::REG_CHANNEL_COUNT: prdata = {27'd0, cfg.channel_count};
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/wpu_core.sv =====
// -----------------------------------------------------------------------------
// WPU parser core
// Marker search, chunk length capture and PCM sample assembly for one byte.
// -----------------------------------------------------------------------------
module wpu_core #(
  parameter int unsigned MAX_CHANNELS = wpu_pkg::DEF_MAX_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  wpu_pkg::in_item_t   item,
  input  wpu_pkg::cfg_t       cfg,
  output logic                emit,
  output wpu_pkg::out_item_t  res
);

  localparam int unsigned CI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NCH_W  = ($clog2(MAX_CHANNELS + 1) > 5) ?
                                   $clog2(MAX_CHANNELS + 1) : 5;
  localparam int unsigned FB_W   = NCH_W + 2;
  localparam logic [NCH_W-1:0] MAX_NCH = NCH_W'(MAX_CHANNELS);

  // Parser state.
  wpu_pkg::phase_t phase, phase_next;
  logic [23:0]     match_window, match_window_next;
  logic [1:0]      length_byte_count, length_byte_count_next;
  logic [31:0]     bytes_left, bytes_left_next;
  logic [1:0]      byte_in_sample, byte_in_sample_next;
  logic [23:0]     sample_accum, sample_accum_next;
  logic [CI_W-1:0] channel_index, channel_index_next;

  // State as seen by this byte, after an optional restart.
  wpu_pkg::phase_t cur_phase;
  logic [23:0]     cur_window;
  logic [1:0]      cur_lbc;
  logic [31:0]     cur_left;
  logic [1:0]      cur_bis;
  logic [23:0]     cur_accum;
  logic [CI_W-1:0] cur_ci;

  logic [1:0]       nbytes;
  logic [NCH_W-1:0] cc_ext;
  logic [NCH_W-1:0] nch;
  logic [FB_W-1:0]  frame_bytes;
  logic [31:0]      len_new;
  logic [31:0]      left_dec;
  logic [2:0]       pos;
  logic [23:0]      accum_new;
  logic             frame_end;
  logic             last;
  logic [CI_W+3:0]  ci_wide;
  logic [7:0]       b;

  assign b = item.data_byte;

  // Effective configuration: zero widths and counts act as one, counts clamp.
  always_comb begin
    nbytes = (cfg.sample_bytes == 2'd0) ? 2'd1 : cfg.sample_bytes;
    cc_ext = NCH_W'(cfg.channel_count);
    if (cc_ext == '0) begin
      nch = NCH_W'(1);
    end else if (cc_ext > MAX_NCH) begin
      nch = MAX_NCH;
    end else begin
      nch = cc_ext;
    end
    frame_bytes = FB_W'(nbytes) * FB_W'(nch);
  end

  // Restart clears the parser before the byte is handled.
  always_comb begin
    if (item.restart) begin
      cur_phase  = wpu_pkg::PH_SEARCH;
      cur_window = '0;
      cur_lbc    = '0;
      cur_left   = '0;
      cur_bis    = '0;
      cur_accum  = '0;
      cur_ci     = '0;
    end else begin
      cur_phase  = phase;
      cur_window = match_window;
      cur_lbc    = length_byte_count;
      cur_left   = bytes_left;
      cur_bis    = byte_in_sample;
      cur_accum  = sample_accum;
      cur_ci     = channel_index;
    end
  end

  // Length byte merged into its little-endian lane.
  always_comb begin
    len_new = cur_left;
    case (cur_lbc)
      2'd0:    len_new[7:0]   = cur_left[7:0]   | b;
      2'd1:    len_new[15:8]  = cur_left[15:8]  | b;
      2'd2:    len_new[23:16] = cur_left[23:16] | b;
      default: len_new[31:24] = cur_left[31:24] | b;
    endcase
  end

  // Sample assembly: 8-bit samples are re-biased, wider ones fill up to the top.
  always_comb begin
    pos       = 3'({1'b0, cur_bis} + 3'd3 - {1'b0, nbytes});
    accum_new = cur_accum;
    if (nbytes == 2'd1) begin
      accum_new = {b ^ wpu_pkg::SAMPLE_BIAS, 16'd0};
    end else begin
      case (pos)
        3'd0:    accum_new[7:0]   = cur_accum[7:0]   | b;
        3'd1:    accum_new[15:8]  = cur_accum[15:8]  | b;
        3'd2:    accum_new[23:16] = cur_accum[23:16] | b;
        default: accum_new = cur_accum;
      endcase
    end
  end

  assign left_dec  = cur_left - 32'd1;
  assign frame_end = ((NCH_W + 1)'(cur_ci) + (NCH_W + 1)'(1)) >= (NCH_W + 1)'(nch);
  assign last      = frame_end && (left_dec < 32'(frame_bytes));
  assign ci_wide   = {4'd0, cur_ci};

  // Next state and result for this byte.
  always_comb begin
    phase_next             = cur_phase;
    match_window_next      = cur_window;
    length_byte_count_next = cur_lbc;
    bytes_left_next        = cur_left;
    byte_in_sample_next    = cur_bis;
    sample_accum_next      = cur_accum;
    channel_index_next     = cur_ci;
    emit                   = 1'b0;
    res.sample             = $signed(accum_new);
    res.channel            = ci_wide[3:0];
    res.last_in_data       = last;

    unique case (cur_phase)
      wpu_pkg::PH_SEARCH: begin
        if (cur_window == wpu_pkg::MARK_DAT && b == wpu_pkg::MARK_A) begin
          phase_next             = wpu_pkg::PH_LENGTH;
          length_byte_count_next = '0;
          bytes_left_next        = '0;
        end
        match_window_next = {cur_window[15:0], b};
      end
      wpu_pkg::PH_LENGTH: begin
        bytes_left_next = len_new;
        if (cur_lbc == 2'd3) begin
          length_byte_count_next = '0;
          byte_in_sample_next    = '0;
          sample_accum_next      = '0;
          channel_index_next     = '0;
          phase_next = (len_new < 32'(frame_bytes)) ? wpu_pkg::PH_DONE
                                                    : wpu_pkg::PH_DATA;
        end else begin
          length_byte_count_next = cur_lbc + 2'd1;
        end
      end
      wpu_pkg::PH_DATA: begin
        bytes_left_next = left_dec;
        if (({1'b0, cur_bis} + 3'd1) < {1'b0, nbytes}) begin
          byte_in_sample_next = cur_bis + 2'd1;
          sample_accum_next   = accum_new;
        end else begin
          // Sample complete: hand it out and step the channel.
          emit                = 1'b1;
          byte_in_sample_next = '0;
          sample_accum_next   = '0;
          channel_index_next  = frame_end ? '0 : cur_ci + CI_W'(1);
          if (last) begin
            phase_next = wpu_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, updated when the held byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wpu_pkg::PH_SEARCH;
      match_window      <= '0;
      length_byte_count <= '0;
      bytes_left        <= '0;
      byte_in_sample    <= '0;
      sample_accum      <= '0;
      channel_index     <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      match_window      <= match_window_next;
      length_byte_count <= length_byte_count_next;
      bytes_left        <= bytes_left_next;
      byte_in_sample    <= byte_in_sample_next;
      sample_accum      <= sample_accum_next;
      channel_index     <= channel_index_next;
    end
  end

endmodule

// ===== hdl/wpu_checker.sv =====
// -----------------------------------------------------------------------------
// WPU port checker
// Concurrent checks on the stream ports of the unpacker, attached by bind.
// -----------------------------------------------------------------------------
module wpu_checker (
  input logic               clk,
  input logic               rst,
  input wpu_pkg::in_item_t  item,
  input logic               item_valid,
  input logic               item_ready,
  input wpu_pkg::out_item_t result,
  input logic               result_valid,
  input logic               result_ready
);

  // A stalled sample stays valid and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // With the output free or draining, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    (result_ready || !result_valid) |-> item_ready)
    else $error("input stalled while output could move");

  // A new sample always comes from an accepted byte that passed the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result appeared without a matching request");

  // A restart byte returns to marker search and never completes a sample.
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(item_valid && item_ready && item.restart, 2) |-> !$rose(result_valid))
    else $error("restart byte produced a sample");

endmodule

bind wav_pcm_stream_unpacker wpu_checker u_wpu_checker (.*);

// ===== verif/wpu_sample_checker.sv =====
// -----------------------------------------------------------------------------
// WAV PCM unpacker sample checker
// Watches the byte, sample and register channels of the unpacker. It keeps its
// own parser state and register copy, works out the samples each accepted byte
// should produce, and compares every accepted sample against the oldest one.
// -----------------------------------------------------------------------------
module wpu_sample_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [wpu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  wpu_pkg::in_item_t          item,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  wpu_pkg::out_item_t         result,
  input  logic                       result_valid,
  input  logic                       result_ready,
  output int unsigned                fail_count,
  output int unsigned                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wpu_pkg::*;

  localparam int unsigned MAX_CH = DEF_MAX_CHANNELS;

  // Register copy.
  logic [1:0]  cfg_bytes;
  logic [4:0]  cfg_chans;

  // Parser state.
  phase_t      ph;
  logic [23:0] window;
  logic [1:0]  len_idx;
  logic [31:0] remaining;
  logic [1:0]  byte_pos;
  logic [23:0] accum;
  logic [3:0]  chan_idx;

  out_item_t   expected_samples[$];

  function automatic void clear_parser();
    ph        = PH_SEARCH;
    window    = '0;
    len_idx   = '0;
    remaining = '0;
    byte_pos  = '0;
    accum     = '0;
    chan_idx  = '0;
  endfunction

  // Runs one byte through the parser; returns 1 when it completes a sample.
  function automatic bit unpack_byte(input in_item_t req, output out_item_t smp);
    int unsigned nb;
    int unsigned nch;
    int unsigned fbytes;
    int unsigned pos;
    bit          frame_end;
    bit          is_last;
    nb = (cfg_bytes == 2'd0) ? 1 : cfg_bytes;
    nch = (cfg_chans == 5'd0) ? 1 : ((cfg_chans > MAX_CH) ? MAX_CH : cfg_chans);
    fbytes = nb * nch;
    smp = '0;
    if (req.restart) clear_parser();
    case (ph)
      PH_SEARCH: begin
        if (window == MARK_DAT && req.data_byte == MARK_A) begin
          ph = PH_LENGTH;
          len_idx = '0;
          remaining = '0;
        end
        window = {window[15:0], req.data_byte};
        return 1'b0;
      end
      PH_LENGTH: begin
        // Chunk length arrives least significant byte first.
        remaining = remaining | (32'(req.data_byte) << (8 * len_idx));
        if (len_idx == 2'd3) begin
          len_idx = '0;
          byte_pos = '0;
          accum = '0;
          chan_idx = '0;
          ph = (remaining < fbytes) ? PH_DONE : PH_DATA;
        end else begin
          len_idx = len_idx + 2'd1;
        end
        return 1'b0;
      end
      PH_DATA: begin
        remaining = remaining - 32'd1;
        if (nb == 1) begin
          accum = {req.data_byte ^ SAMPLE_BIAS, 16'h0000};
        end else begin
          // Bytes fill upward so the sample ends at the top of 24 bits; anything past it is lost.
          pos = byte_pos + 3 - nb;
          if (pos <= 2) accum = accum | (24'(req.data_byte) << (8 * pos));
        end
        if (byte_pos + 1 < nb) begin
          byte_pos = byte_pos + 2'd1;
          return 1'b0;
        end
        frame_end = (chan_idx + 1 >= nch);
        is_last = frame_end && (remaining < fbytes);
        smp.sample = accum;
        smp.channel = chan_idx;
        smp.last_in_data = is_last;
        byte_pos = '0;
        accum = '0;
        chan_idx = frame_end ? 4'd0 : chan_idx + 4'd1;
        if (is_last) ph = PH_DONE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      cfg_bytes = SAMPLE_BYTES_RST;
      cfg_chans = CHANNEL_COUNT_RST;
      clear_parser();
      expected_samples.delete();
      fail_count = 0;
    end else begin
      // Samples leaving the block come from earlier bytes, so check them first.
      if (result_valid && result_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample with none expected: sample %0d channel %0d last %0b",
                 result.sample, result.channel, result.last_in_data);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (result.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, result.sample);
            fail_count++;
          end
          if (result.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, result.channel);
            fail_count++;
          end
          if (result.last_in_data !== want.last_in_data) begin
            $error("last_in_data: expected %0b, got %0b",
                   want.last_in_data, result.last_in_data);
            fail_count++;
          end
        end
      end

      // Register writes.
      if (psel && penable && pwrite && pready) begin
        if (paddr[ADDR_W-1:2] == REG_SAMPLE_BYTES) cfg_bytes = pwdata[1:0];
        else if (paddr[ADDR_W-1:2] == REG_CHANNEL_COUNT) cfg_chans = pwdata[4:0];
      end

      // Accepted bytes.
      if (item_valid && item_ready) begin
        if (unpack_byte(item, fresh)) expected_samples.push_back(fresh);
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== verif/testbench.sv =====
// -----------------------------------------------------------------------------
// WAV PCM unpacker testbench
// Drives byte streams with "data" chunks of random length through the
// unpacker under several register settings and handshake pressure, while a
// checker instance predicts and compares every decoded sample.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpu_pkg::*;

  localparam int unsigned NUM_REQS      = 1900;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  in_item_t            item;
  logic                item_valid;
  logic                item_ready;
  out_item_t           result;
  logic                result_valid;
  logic                result_ready;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned         send_idle_pct;
  int unsigned         stall_pct;
  int unsigned         hold_reqs;
  int unsigned         sent_reqs;
  logic [1:0]          cur_bytes;
  logic [4:0]          cur_chans;

  wav_pcm_stream_unpacker dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  wpu_sample_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Sample receiver: random stalls, plus long hold-offs on request.
  initial begin : receiver
    int unsigned seen;
    seen = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one byte, idling cycle by cycle first, and waits for acceptance.
  task automatic send_req(input logic [7:0] data, input logic restart);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: data, restart: restart};
    do @(posedge clk); while (!item_ready);
    sent_reqs++;
  endtask

  // Stops sending and waits until every expected sample has come out.
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SAMPLE_BYTES) cur_bytes = value[1:0];
    else cur_chans = value[4:0];
  endtask

  // Random register setting; channel counts out of range now and then.
  task automatic pick_config();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    drain_results();
    write_reg(REG_SAMPLE_BYTES, $urandom_range(0, 3));
    if (sel < 6) write_reg(REG_CHANNEL_COUNT, $urandom_range(1, 4));
    else if (sel < 8) write_reg(REG_CHANNEL_COUNT, DEF_MAX_CHANNELS);
    else if (sel == 8) write_reg(REG_CHANNEL_COUNT, 32'd0);
    else write_reg(REG_CHANNEL_COUNT, $urandom_range(17, 31));
  endtask

  // Sends the "data" marker; restart rides on its first byte if asked.
  task automatic send_marker(input logic restart);
    send_req(MARK_DAT[23:16], restart);
    send_req(MARK_DAT[15:8], 1'b0);
    send_req(MARK_DAT[7:0], 1'b0);
    send_req(MARK_A, 1'b0);
  endtask

  // One stream: restart, some noise, a marker, then a length and sample bytes unless the marker is broken.
  task automatic run_stream();
    int unsigned kind;
    int unsigned nfill;
    int unsigned ndata;
    int unsigned fbytes;
    int unsigned i;
    logic [31:0] len;
    if ($urandom_range(0, 99) < 15) pick_config();
    fbytes = ((cur_bytes == 2'd0) ? 1 : cur_bytes) *
             ((cur_chans == 5'd0) ? 1 : ((cur_chans > DEF_MAX_CHANNELS) ?
                                         DEF_MAX_CHANNELS : cur_chans));
    nfill = $urandom_range(0, 3);
    for (i = 0; i < nfill; i++) begin
      send_req(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 99) < 3));
    end
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // Broken marker: "dat" and then an arbitrary byte.
      send_req(MARK_DAT[23:16], nfill == 0);
      send_req(MARK_DAT[15:8], 1'b0);
      send_req(MARK_DAT[7:0], 1'b0);
      send_req(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    send_marker(nfill == 0);
    if (kind < 16) begin
      // Huge length: cut short by the next restart.
      len = $urandom;
      ndata = $urandom_range(1, 40);
    end else if (kind < 22) begin
      // Too short for a whole frame.
      len = $urandom_range(0, fbytes - 1);
      ndata = $urandom_range(0, 3);
    end else begin
      len = fbytes * $urandom_range(1, 4) + $urandom_range(0, fbytes - 1);
      ndata = len + $urandom_range(0, 2);
    end
    for (i = 0; i < 4; i++) send_req(len[8*i +: 8], 1'b0);
    for (i = 0; i < ndata; i++) begin
      if (i == ndata / 2 && $urandom_range(0, 99) < 6) pick_config();
      send_req(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned p;
    int unsigned i;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item = '0;
    item_valid = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    sent_reqs = 0;
    cur_bytes = SAMPLE_BYTES_RST;
    cur_chans = CHANNEL_COUNT_RST;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // 16-bit extremes inside a chunk too long to end.
    send_marker(1'b1);
    for (i = 0; i < 4; i++) send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'h80, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h7F, 1'b0);

    // 24-bit maximum on channel 0, then a sample cut to 16 bits mid-way, which
    // drops its third byte.
    drain_results();
    write_reg(REG_SAMPLE_BYTES, 32'd3);
    write_reg(REG_CHANNEL_COUNT, 32'd2);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h7F, 1'b0);
    send_req(8'h34, 1'b0);
    send_req(8'h12, 1'b0);
    drain_results();
    write_reg(REG_SAMPLE_BYTES, 32'd2);
    send_req(8'h56, 1'b0);

    // Zero sample size and zero channel count act as one: 8-bit extremes.
    drain_results();
    write_reg(REG_SAMPLE_BYTES, 32'd0);
    write_reg(REG_CHANNEL_COUNT, 32'd0);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);

    // Zero length goes straight to done; a later marker is ignored.
    send_marker(1'b1);
    for (i = 0; i < 4; i++) send_req(8'h00, 1'b0);
    send_marker(1'b0);

    // Long receiver hold-off with the sender pushing 8-bit samples.
    drain_results();
    write_reg(REG_SAMPLE_BYTES, 32'd1);
    write_reg(REG_CHANNEL_COUNT, 32'd1);
    send_marker(1'b1);
    send_req(8'd48, 1'b0);
    for (i = 0; i < 3; i++) send_req(8'h00, 1'b0);
    hold_reqs++;
    for (i = 0; i < 48; i++) send_req(8'($urandom_range(0, 255)), 1'b0);
    drain_results();

    // Random streams in four handshake phases.
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 55;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      while (sent_reqs < NUM_REQS * (p + 1) / 4) run_stream();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wpu_pkg.sv
hdl/wpu_regs.sv
hdl/wpu_core.sv
hdl/wav_pcm_stream_unpacker.sv
hdl/wpu_checker.sv
verif/wpu_sample_checker.sv
verif/testbench.sv
